// File: rtl/sit_pkg.sv
// Shared types, constants and codes for the symbol interning table.
package sit_pkg;

    localparam int TABLE_BYTES_DEF  = 4096;
    localparam int MAX_NAME_LEN_DEF = 255;

    // Collected-length counter: one count above the longest legal name.
    localparam int LEN_W      = 9;
    // Byte index into one staged name.
    localparam int NAME_IDX_W = 8;
    // Names staged between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // One completed name waiting for the back end.
    typedef struct packed {
        logic                  too_long;
        logic [NAME_IDX_W-1:0] len;
    } desc_t;

    // Front to queue: byte write and descriptor push.
    typedef struct packed {
        logic                  wr_en;
        logic [NAME_IDX_W-1:0] wr_idx;
        logic [7:0]            wr_data;
        logic                  push;
        desc_t                 desc;
    } front_req_t;

    // Back to queue: name byte read and pop.
    typedef struct packed {
        logic                  pop;
        logic [NAME_IDX_W-1:0] rd_idx;
    } back_req_t;

    // Queue to back: head of the queue.
    typedef struct packed {
        logic  valid;
        desc_t desc;
    } q_head_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_HEAD,
        B_CMP,
        B_WRITE,
        B_RESULT
    } back_state_t;

endpackage

// File: rtl/symbol_interning_table.sv
// Top level of the symbol interning table: front, name queue and table engine.
// Usage
//   The slave stream carries a name one byte per beat: s_tdata is the byte and
//   s_tlast marks the final byte. Every name must hold at least one byte.
//   One result beat per completed name: entry offset, found flag and status
//   (ok, name too long, table full). Errors report offset 0, found 0 and
//   leave the table untouched.
// Timing
//   Bytes are taken one per cycle while the queue has room. A two-name
//   queue stages completed names, so the next name streams in while the
//   engine works on the last one. The walk runs through the single read
//   port of the store: each skipped entry passes B_SCAN and B_HEAD, and an
//   entry of equal length adds a B_CMP step per compared byte. A miss ends
//   in B_SCAN at the end of the table; an append then writes length + 1
//   bytes, one per cycle. m_tvalid rises once the engine has picked up the
//   name and finished the walk; an overlong name skips the walk. The engine
//   passes B_IDLE after each result beat.
// Reset and stalls
//   Reset clears the fill pointer and the queue; no clearing pass is needed.
//   A result holds on m_tdata until m_tready. Intake stalls (s_tready low)
//   only once two completed names wait in the queue.
module symbol_interning_table #(
    parameter  int TABLE_BYTES  = sit_pkg::TABLE_BYTES_DEF,
    parameter  int MAX_NAME_LEN = sit_pkg::MAX_NAME_LEN_DEF,
    localparam int AW           = $clog2(TABLE_BYTES),
    localparam int OUT_W        = ((AW + 3 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] name_byte
    input  logic             s_tlast,   // last_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // entry_offset, already_present, status, zero pad
);
    import sit_pkg::*;

    front_req_t freq;
    back_req_t  breq;
    q_head_t    head;
    logic       q_full;
    logic [7:0] name_rdata;

    // Intake: length count, overlong flag, byte staging.
    sit_front #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .req      (freq)
    );

    // Decouple intake from the table walk.
    sit_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .freq       (freq),
        .full       (q_full),
        .breq       (breq),
        .head       (head),
        .name_rdata (name_rdata)
    );

    // Search, append and report.
    sit_back #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .name_rdata (name_rdata),
        .breq       (breq),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: rtl/sit_front.sv
// Byte intake: counts name length, flags overlong names, stages bytes.
module sit_front #(
    parameter int MAX_NAME_LEN = sit_pkg::MAX_NAME_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] name_byte
    input  logic                s_tlast,   // last_byte
    input  logic                q_full,
    output sit_pkg::front_req_t req
);
    import sit_pkg::*;

    logic [LEN_W-1:0] name_len_reg;
    logic [LEN_W-1:0] name_len_next;
    logic [LEN_W-1:0] len_inc;
    logic             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Saturate one above the limit so an overlong name stays flagged.
    assign len_inc = (name_len_reg <= LEN_W'(MAX_NAME_LEN)) ?
                     LEN_W'(name_len_reg + LEN_W'(1)) : name_len_reg;

    always_comb
    begin
        req.wr_en         = accept && (name_len_reg < LEN_W'(MAX_NAME_LEN));
        req.wr_idx        = name_len_reg[NAME_IDX_W-1:0];
        req.wr_data       = s_tdata;
        req.push          = accept && s_tlast;
        req.desc.too_long = len_inc > LEN_W'(MAX_NAME_LEN);
        req.desc.len      = len_inc[NAME_IDX_W-1:0];
        name_len_next     = name_len_reg;
        if (accept)
        begin
            name_len_next = s_tlast ? '0 : len_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_len_reg <= '0;
        end
        else
        begin
            name_len_reg <= name_len_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (name_len_reg == '0))
        else $error("length counter not cleared after a name");

    assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> (name_len_reg < LEN_W'(MAX_NAME_LEN)))
        else $error("byte staged beyond the name limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        name_len_reg <= LEN_W'(MAX_NAME_LEN + 1))
        else $error("length counter past saturation");

endmodule

// File: rtl/sit_queue.sv
// Name queue: banked byte buffer plus descriptors between front and back.
module sit_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  sit_pkg::front_req_t freq,
    output logic                full,
    input  sit_pkg::back_req_t  breq,
    output sit_pkg::q_head_t    head,
    output logic [7:0]          name_rdata
);
    import sit_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [7:0] nbuf_mem [QUEUE_DEPTH * (2 ** NAME_IDX_W)];
    desc_t      desc_reg [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       name_rdata_reg;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.desc  = desc_reg[rd_ptr_reg];
    assign name_rdata = name_rdata_reg;

    always_comb
    begin
        count_next = count_reg;
        if (freq.push && !breq.pop)
        begin
            count_next = CNT_W'(count_reg + CNT_W'(1));
        end
        else if (!freq.push && breq.pop)
        begin
            count_next = CNT_W'(count_reg - CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (freq.push)
            begin
                wr_ptr_reg <= PTR_W'(wr_ptr_reg + PTR_W'(1));
            end
            if (breq.pop)
            begin
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + PTR_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (freq.push)
        begin
            desc_reg[wr_ptr_reg] <= freq.desc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (freq.wr_en)
        begin
            nbuf_mem[{wr_ptr_reg, freq.wr_idx}] <= freq.wr_data;
        end
        name_rdata_reg <= nbuf_mem[{rd_ptr_reg, breq.rd_idx}];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(freq.push && full))
        else $error("push into a full name queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        breq.pop |-> head.valid)
        else $error("pop from an empty name queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with the count");

endmodule

// File: rtl/sit_back.sv
// Table engine: walks the packed symbol store, compares, appends, reports.
module sit_back #(
    parameter  int TABLE_BYTES = sit_pkg::TABLE_BYTES_DEF,
    localparam int AW          = $clog2(TABLE_BYTES),
    localparam int OUT_W       = ((AW + 3 + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sit_pkg::q_head_t   head,
    input  logic [7:0]         name_rdata,
    output sit_pkg::back_req_t breq,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata
);
    import sit_pkg::*;

    logic [7:0] store_mem [TABLE_BYTES];
    logic [7:0] store_rdata_reg;

    back_state_t state_reg;
    back_state_t state_next;

    logic [AW-1:0]         loc_reg,  loc_next;
    logic [AW-1:0]         fp_reg,   fp_next;
    logic [NAME_IDX_W-1:0] idx_reg,  idx_next;
    logic [AW-1:0]         res_offset_reg, res_offset_next;
    logic                  res_found_reg,  res_found_next;
    status_t               res_status_reg, res_status_next;

    logic [AW-1:0] store_raddr;
    logic [AW-1:0] store_waddr;
    logic [7:0]    store_wdata;
    logic          store_we;

    logic [NAME_IDX_W-1:0] len;
    logic [AW:0]           fill_sum;
    logic                  at_end;
    logic                  table_full;
    logic                  len_match;
    logic                  byte_eq;
    logic                  last_cmp;
    logic                  write_done;

    assign len        = head.desc.len;
    assign fill_sum   = {1'b0, fp_reg} + (AW+1)'(len) + (AW+1)'(1);
    assign at_end     = loc_reg == fp_reg;
    assign table_full = fill_sum >= (AW+1)'(TABLE_BYTES);
    assign len_match  = store_rdata_reg == len;
    assign byte_eq    = store_rdata_reg == name_rdata;
    assign last_cmp   = idx_reg == NAME_IDX_W'(len - NAME_IDX_W'(1));
    assign write_done = idx_reg == len;

    assign m_tvalid = state_reg == B_RESULT;
    assign m_tdata  = OUT_W'({res_status_reg, res_found_reg, res_offset_reg});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = head.desc.too_long ? B_RESULT : B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (!at_end)
                begin
                    state_next = B_HEAD;
                end
                else
                begin
                    state_next = table_full ? B_RESULT : B_WRITE;
                end
            end
            B_HEAD:
            begin
                state_next = len_match ? B_CMP : B_SCAN;
            end
            B_CMP:
            begin
                if (!byte_eq)
                begin
                    state_next = B_SCAN;
                end
                else if (last_cmp)
                begin
                    state_next = B_RESULT;
                end
            end
            B_WRITE:
            begin
                if (write_done)
                begin
                    state_next = B_RESULT;
                end
            end
            B_RESULT:
            begin
                if (m_tready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        loc_next        = loc_reg;
        fp_next         = fp_reg;
        idx_next        = idx_reg;
        res_offset_next = res_offset_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        store_raddr     = loc_reg;
        store_waddr     = AW'(fp_reg + AW'(idx_reg));
        store_wdata     = (idx_reg == '0) ? len : name_rdata;
        store_we        = 1'b0;
        breq.pop        = 1'b0;
        breq.rd_idx     = idx_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                loc_next        = '0;
                res_offset_next = '0;
                res_found_next  = 1'b0;
                res_status_next = ST_TOO_LONG;
            end
            B_SCAN:
            begin
                idx_next        = '0;
                res_status_next = ST_FULL;
            end
            B_HEAD:
            begin
                // Prefetch the first body byte and the first name byte.
                store_raddr = AW'(loc_reg + AW'(1));
                breq.rd_idx = '0;
                idx_next    = '0;
                if (!len_match)
                begin
                    loc_next = AW'(loc_reg + AW'(store_rdata_reg) + AW'(1));
                end
            end
            B_CMP:
            begin
                store_raddr = AW'(loc_reg + AW'(idx_reg) + AW'(2));
                breq.rd_idx = NAME_IDX_W'(idx_reg + NAME_IDX_W'(1));
                idx_next    = NAME_IDX_W'(idx_reg + NAME_IDX_W'(1));
                if (!byte_eq)
                begin
                    loc_next = AW'(loc_reg + AW'(len) + AW'(1));
                end
                else if (last_cmp)
                begin
                    res_offset_next = loc_reg;
                    res_found_next  = 1'b1;
                    res_status_next = ST_OK;
                end
            end
            B_WRITE:
            begin
                // Length byte first, then each name byte in the cycle after its read.
                store_we = 1'b1;
                idx_next = NAME_IDX_W'(idx_reg + NAME_IDX_W'(1));
                if (write_done)
                begin
                    fp_next         = AW'(fill_sum);
                    res_offset_next = fp_reg;
                    res_found_next  = 1'b0;
                    res_status_next = ST_OK;
                end
            end
            B_RESULT:
            begin
                breq.pop = m_tready;
            end
            default:
            begin
                loc_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            fp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fp_reg    <= fp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        loc_reg        <= loc_next;
        idx_reg        <= idx_next;
        res_offset_reg <= res_offset_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        store_rdata_reg <= store_mem[store_raddr];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status_reg != ST_OK)) |->
        ((res_offset_reg == '0) && !res_found_reg))
        else $error("error result carries an offset or found flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CMP) |-> (idx_reg < len))
        else $error("compare index ran past the name");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> head.valid)
        else $error("engine busy without a queued name");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SCAN) |-> (loc_reg <= fp_reg))
        else $error("table walk overran the fill pointer");

endmodule
